// File: design/alc_pkg.sv
`timescale 1ns / 1ps

package alc_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int CHUNK_SIZE   = 128;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 12;
    localparam int LEVEL_MAX = 4080;

    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CHUNK_W = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
    localparam int ACC_W   = CNT_W + SAMPLE_W + 1;
    localparam int DIV_W   = ACC_W + 4;
    localparam int STEP_W  = $clog2(DIV_W);
    localparam int MEAN_W  = SAMPLE_W + 1;
    localparam int DIFF_W  = SAMPLE_W + 2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV1 = 5'b00100,
        S_DEV  = 5'b01000,
        S_DIV2 = 5'b10000
    } t_state;

endpackage

// File: design/audio_level_and_chunker_unit.sv
`timescale 1ns / 1ps

// Audio level meter and chunker.
// Items enter on start while busy is low: i_op selects a sample or a flush, with
// i_sample and i_buffer_last. The recording enable is written on the cfg channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data) while the block is idle.
// Each result is shown for exactly one cycle, marked by o_result_strobe; the
// receiver cannot stall it, so it must take every result when it is shown.
// A sample that is not the last of its buffer, and a flush, leave busy low:
// the result appears in the cycle after the transaction, and the next
// item can be taken at once, so one item per cycle is sustained.
// The last sample of a buffer starts the level measurement, which holds busy
// high until the level is shown. Two passes read the n stored samples (n up
// to 256) from the sample memory one entry per cycle (sum, then absolute
// deviation), each followed by one division through the shared restoring
// divider of DIV_W = 22 steps.
// Reset clears the counts, the enable and the sequencer; the sample memory
// needs no clearing since only entries written in the current buffer are read.
module audio_level_and_chunker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [alc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_buffer_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_result_strobe,
    output logic                          o_data_valid,
    output logic [alc_pkg::SAMPLE_W-1:0]  o_data_byte,
    output logic                          o_chunk_end,
    output logic                          o_level_valid,
    output logic [alc_pkg::LEVEL_W-1:0]   o_level,
    output logic                          o_level_overflow
);

    alc_pkg::t_state r_state;

    logic [alc_pkg::SAMPLE_W-1:0] r_mem [alc_pkg::BUFFER_DEPTH];
    logic [alc_pkg::SAMPLE_W-1:0] r_mem_q;

    logic                         r_rec_en;
    logic [alc_pkg::CNT_W-1:0]    r_count;
    logic [alc_pkg::CHUNK_W-1:0]  r_chunk_fill;
    logic                         r_ovf_seen;
    logic                         r_ovf_out;
    logic [alc_pkg::CNT_W-1:0]    r_n;
    logic [alc_pkg::CNT_W-1:0]    r_idx;
    logic                         r_pend;
    logic signed [alc_pkg::ACC_W-1:0] r_acc;
    logic                         r_neg;
    logic signed [alc_pkg::MEAN_W-1:0] r_mean;
    logic [alc_pkg::CNT_W-1:0]    r_rem;
    logic [alc_pkg::DIV_W-1:0]    r_quo;
    logic [alc_pkg::STEP_W-1:0]   r_step;

    logic                         accept;
    logic                         sample_go;
    logic                         can_store;
    logic [alc_pkg::CHUNK_W:0]    fill_inc;
    logic                         chunk_full;
    logic                         rd_en;
    logic signed [alc_pkg::ACC_W-1:0] x_ext;
    logic signed [alc_pkg::DIFF_W-1:0] diff;
    logic [alc_pkg::DIFF_W-1:0]   diff_abs;
    logic [alc_pkg::ACC_W-1:0]    acc_abs;
    logic [alc_pkg::CNT_W:0]      rem_sh;
    logic                         rem_ge;
    logic [alc_pkg::CNT_W:0]      rem_nx;
    logic [alc_pkg::DIV_W-1:0]    quo_nx;
    logic                         div_last;
    logic [alc_pkg::MEAN_W-1:0]   mean_mag;

    assign busy        = (r_state != alc_pkg::S_IDLE);
    assign o_cfg_ready = ~busy;
    assign accept      = start & ~busy;
    assign sample_go   = accept & (i_op == alc_pkg::OP_SAMPLE) & r_rec_en;
    assign can_store   = (r_count < alc_pkg::CNT_W'(alc_pkg::BUFFER_DEPTH));
    assign fill_inc    = {1'b0, r_chunk_fill} + 1'b1;
    assign chunk_full  = (fill_inc >= (alc_pkg::CHUNK_W + 1)'(alc_pkg::CHUNK_SIZE));

    assign rd_en    = (r_state == alc_pkg::S_SUM || r_state == alc_pkg::S_DEV) && (r_idx < r_n);
    assign x_ext    = alc_pkg::ACC_W'($signed(r_mem_q));
    assign diff     = alc_pkg::DIFF_W'($signed(r_mem_q)) - alc_pkg::DIFF_W'(r_mean);
    assign diff_abs = diff[alc_pkg::DIFF_W-1] ? alc_pkg::DIFF_W'(-diff) : alc_pkg::DIFF_W'(diff);
    assign acc_abs  = r_acc[alc_pkg::ACC_W-1] ? alc_pkg::ACC_W'(-r_acc) : alc_pkg::ACC_W'(r_acc);

    assign rem_sh   = {r_rem, r_quo[alc_pkg::DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_n});
    assign rem_nx   = rem_ge ? (rem_sh - {1'b0, r_n}) : rem_sh;
    assign quo_nx   = {r_quo[alc_pkg::DIV_W-2:0], rem_ge};
    assign div_last = (r_step == alc_pkg::STEP_W'(alc_pkg::DIV_W - 1));
    assign mean_mag = quo_nx[alc_pkg::MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (sample_go && can_store) begin
            r_mem[r_count[alc_pkg::ADDR_W-1:0]] <= i_sample;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_idx[alc_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= alc_pkg::S_IDLE;
            r_rec_en        <= 1'b0;
            r_count         <= '0;
            r_chunk_fill    <= '0;
            r_ovf_seen      <= 1'b0;
            r_pend          <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rec_en <= i_cfg_data;
            end
            case (r_state)
                alc_pkg::S_IDLE: begin
                    if (accept && i_op == alc_pkg::OP_FLUSH) begin
                        if (r_chunk_fill != '0) begin
                            r_chunk_fill     <= '0;
                            o_result_strobe  <= 1'b1;
                            o_data_valid     <= 1'b0;
                            o_data_byte      <= '0;
                            o_chunk_end      <= 1'b1;
                            o_level_valid    <= 1'b0;
                            o_level          <= '0;
                            o_level_overflow <= 1'b0;
                        end
                    end else if (sample_go) begin
                        o_data_valid     <= 1'b1;
                        o_data_byte      <= i_sample;
                        o_chunk_end      <= chunk_full;
                        o_level_valid    <= 1'b0;
                        o_level          <= '0;
                        o_level_overflow <= 1'b0;
                        r_chunk_fill     <= chunk_full ? '0 : fill_inc[alc_pkg::CHUNK_W-1:0];
                        if (i_buffer_last) begin
                            r_n        <= can_store ? (r_count + 1'b1) : r_count;
                            r_ovf_out  <= r_ovf_seen | ~can_store;
                            r_count    <= '0;
                            r_ovf_seen <= 1'b0;
                            r_idx      <= '0;
                            r_pend     <= 1'b0;
                            r_acc      <= '0;
                            r_state    <= alc_pkg::S_SUM;
                        end else begin
                            o_result_strobe <= 1'b1;
                            if (can_store) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_ovf_seen <= 1'b1;
                            end
                        end
                    end
                end
                alc_pkg::S_SUM, alc_pkg::S_DEV: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend) begin
                        r_acc <= (r_state == alc_pkg::S_SUM) ? (r_acc + x_ext)
                                 : (r_acc + alc_pkg::ACC_W'(diff_abs));
                    end
                    if (!rd_en && !r_pend) begin
                        r_rem  <= '0;
                        r_step <= '0;
                        if (r_state == alc_pkg::S_SUM) begin
                            r_neg   <= r_acc[alc_pkg::ACC_W-1];
                            r_quo   <= alc_pkg::DIV_W'(acc_abs);
                            r_state <= alc_pkg::S_DIV1;
                        end else begin
                            r_quo   <= alc_pkg::DIV_W'(acc_abs) << 4;
                            r_state <= alc_pkg::S_DIV2;
                        end
                    end
                end
                alc_pkg::S_DIV1, alc_pkg::S_DIV2: begin
                    r_rem  <= rem_nx[alc_pkg::CNT_W-1:0];
                    r_quo  <= quo_nx;
                    r_step <= r_step + 1'b1;
                    if (div_last) begin
                        if (r_state == alc_pkg::S_DIV1) begin
                            r_mean  <= r_neg ? $signed(-mean_mag) : $signed(mean_mag);
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_acc   <= '0;
                            r_state <= alc_pkg::S_DEV;
                        end else begin
                            o_result_strobe  <= 1'b1;
                            o_level_valid    <= 1'b1;
                            o_level          <= (quo_nx > alc_pkg::DIV_W'(alc_pkg::LEVEL_MAX))
                                                ? alc_pkg::LEVEL_W'(alc_pkg::LEVEL_MAX)
                                                : quo_nx[alc_pkg::LEVEL_W-1:0];
                            o_level_overflow <= r_ovf_out;
                            r_state          <= alc_pkg::S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= alc_pkg::S_IDLE;
                end
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Sequencer state is not one-hot.");

    a_level_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_level_valid) |-> o_data_valid)
        else $error("Level reported without a forwarded sample.");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_level_valid) |-> (o_level <= alc_pkg::LEVEL_W'(alc_pkg::LEVEL_MAX)))
        else $error("Level exceeds its saturation limit.");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == alc_pkg::OP_FLUSH && r_chunk_fill == '0) |=> !o_result_strobe)
        else $error("Flush of an empty chunk produced a transaction.");

endmodule

// File: tb/sv/tb_audio_level_and_chunker_unit.sv
`timescale 1ns / 1ps

module tb_audio_level_and_chunker_unit;

    typedef struct packed {
        logic                         data_valid;
        logic [alc_pkg::SAMPLE_W-1:0] data_byte;
        logic                         chunk_end;
        logic                         level_valid;
        logic [alc_pkg::LEVEL_W-1:0]  level;
        logic                         level_overflow;
    } t_chunk_result;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_RESULT,
        CHK_SILENT
    } t_check_kind;

    typedef struct packed {
        logic                         rec;
        logic                         op;
        logic [alc_pkg::SAMPLE_W-1:0] smp;
        logic                         last;
        t_check_kind                  kind;
        t_chunk_result                want;
    } t_dir_row;

    localparam t_chunk_result NO_RESULT = '0;
    localparam int NUM_DIR_ROWS = 19;
    localparam int RANDOM_ITEMS = 1750;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_op = alc_pkg::OP_SAMPLE;
    logic [alc_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic                         i_buffer_last = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic                         i_cfg_data = 1'b0;
    logic                         o_result_strobe;
    logic                         o_data_valid;
    logic [alc_pkg::SAMPLE_W-1:0] o_data_byte;
    logic                         o_chunk_end;
    logic                         o_level_valid;
    logic [alc_pkg::LEVEL_W-1:0]  o_level;
    logic                         o_level_overflow;

    logic [alc_pkg::SAMPLE_W-1:0] stored_samples [alc_pkg::BUFFER_DEPTH];
    int                           stored_cnt = 0;
    int                           chunk_bytes = 0;
    bit                           store_overrun = 0;
    logic                         recording = 1'b0;

    t_chunk_result results_due [$];
    int            error_count = 0;
    int            burst_left = 0;

    // Directed rows: recording setting, item, and how the result is checked.
    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{1'b0, alc_pkg::OP_SAMPLE, 8'h7F, 1'b1, CHK_SILENT,  NO_RESULT},
        '{1'b0, alc_pkg::OP_FLUSH,  8'h00, 1'b0, CHK_SILENT,  NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h80, 1'b1, CHK_RESULT,
          '{1'b1, 8'h80, 1'b0, 1'b1, 12'd0, 1'b0}},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h7F, 1'b0, CHK_RESULT,
          '{1'b1, 8'h7F, 1'b0, 1'b0, 12'd0, 1'b0}},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h80, 1'b1, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_FLUSH,  8'h00, 1'b0, CHK_RESULT,
          '{1'b0, 8'h00, 1'b1, 1'b0, 12'd0, 1'b0}},
        '{1'b1, alc_pkg::OP_FLUSH,  8'h00, 1'b0, CHK_SILENT,  NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h00, 1'b0, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'hFF, 1'b0, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h01, 1'b0, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'hFE, 1'b1, CHK_PREDICT, NO_RESULT},
        '{1'b0, alc_pkg::OP_SAMPLE, 8'h55, 1'b0, CHK_SILENT,  NO_RESULT},
        '{1'b0, alc_pkg::OP_FLUSH,  8'h00, 1'b1, CHK_RESULT,
          '{1'b0, 8'h00, 1'b1, 1'b0, 12'd0, 1'b0}},
        '{1'b0, alc_pkg::OP_SAMPLE, 8'hAA, 1'b1, CHK_SILENT,  NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h81, 1'b0, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h83, 1'b0, CHK_PREDICT, NO_RESULT},
        '{1'b0, alc_pkg::OP_SAMPLE, 8'h10, 1'b1, CHK_SILENT,  NO_RESULT},
        '{1'b1, alc_pkg::OP_SAMPLE, 8'h7E, 1'b1, CHK_PREDICT, NO_RESULT},
        '{1'b1, alc_pkg::OP_FLUSH,  8'h00, 1'b0, CHK_PREDICT, NO_RESULT}
    };

    audio_level_and_chunker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_sample        (i_sample),
        .i_buffer_last   (i_buffer_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_data_valid    (o_data_valid),
        .o_data_byte     (o_data_byte),
        .o_chunk_end     (o_chunk_end),
        .o_level_valid   (o_level_valid),
        .o_level         (o_level),
        .o_level_overflow(o_level_overflow)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit forward_and_measure(input logic op,
                                               input logic [alc_pkg::SAMPLE_W-1:0] smp,
                                               input logic last, output t_chunk_result r);
        int sum;
        int total;
        int mean;
        int dev;
        int lvl;
        r = '0;
        if (op == alc_pkg::OP_FLUSH) begin
            if (chunk_bytes == 0) begin
                return 1'b0;
            end
            chunk_bytes = 0;
            r.chunk_end = 1'b1;
            return 1'b1;
        end
        if (!recording) begin
            return 1'b0;
        end
        if (stored_cnt < alc_pkg::BUFFER_DEPTH) begin
            stored_samples[stored_cnt] = smp;
            stored_cnt++;
        end else begin
            store_overrun = 1'b1;
        end
        r.data_valid = 1'b1;
        r.data_byte = smp;
        chunk_bytes++;
        if (chunk_bytes >= alc_pkg::CHUNK_SIZE) begin
            chunk_bytes = 0;
            r.chunk_end = 1'b1;
        end
        if (last) begin
            sum = 0;
            total = 0;
            for (int i = 0; i < stored_cnt; i++) begin
                sum += int'($signed(stored_samples[i]));
            end
            mean = sum / stored_cnt;
            for (int i = 0; i < stored_cnt; i++) begin
                dev = int'($signed(stored_samples[i])) - mean;
                total += (dev < 0) ? -dev : dev;
            end
            lvl = (total * 16) / stored_cnt;
            if (lvl > alc_pkg::LEVEL_MAX) begin
                lvl = alc_pkg::LEVEL_MAX;
            end
            r.level_valid = 1'b1;
            r.level = lvl[alc_pkg::LEVEL_W-1:0];
            r.level_overflow = store_overrun;
            stored_cnt = 0;
            store_overrun = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_chunk_result want;
        if (i_rst_n && o_result_strobe === 1'b1) begin
            if (results_due.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = results_due.pop_front();
                check_field("data_valid", 32'(o_data_valid), 32'(want.data_valid));
                check_field("data_byte", 32'(o_data_byte), 32'(want.data_byte));
                check_field("chunk_end", 32'(o_chunk_end), 32'(want.chunk_end));
                check_field("level_valid", 32'(o_level_valid), 32'(want.level_valid));
                check_field("level", 32'(o_level), 32'(want.level));
                check_field("level_overflow", 32'(o_level_overflow),
                            32'(want.level_overflow));
            end
        end
    end

    task automatic drive_item(input logic op, input logic [alc_pkg::SAMPLE_W-1:0] smp,
                              input logic last, input t_check_kind kind,
                              input t_chunk_result want);
        int gap;
        bit produces;
        t_chunk_result predicted;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = int'($urandom_range(0, 5));
            if ($urandom_range(0, 29) == 0) begin
                burst_left = int'($urandom_range(10, 60));
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_sample <= smp;
        i_buffer_last <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        produces = forward_and_measure(op, smp, last, predicted);
        case (kind)
            CHK_PREDICT: if (produces) results_due.push_back(predicted);
            CHK_RESULT:  results_due.push_back(want);
            default:     ;
        endcase
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_recording(input logic value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        recording = value;
    endtask

    initial begin
        int fed;
        int buf_no;
        int nbuf;
        int len;
        int cut;
        int mode;
        int base;
        int spread;
        int val;
        logic rec;

        fed = 0;
        buf_no = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].rec != recording) begin
                write_recording(dir_rows[k].rec);
            end
            drive_item(dir_rows[k].op, dir_rows[k].smp, dir_rows[k].last,
                       dir_rows[k].kind, dir_rows[k].want);
        end

        while (fed < RANDOM_ITEMS) begin
            rec = (buf_no < 2 || $urandom_range(0, 4) != 0) ? 1'b1 : 1'b0;
            if (rec != recording || $urandom_range(0, 9) == 0) begin
                write_recording(rec);
            end
            if (!recording) begin
                repeat ($urandom_range(5, 20)) begin
                    drive_item(($urandom_range(0, 3) == 0) ? alc_pkg::OP_FLUSH
                                                           : alc_pkg::OP_SAMPLE,
                               alc_pkg::SAMPLE_W'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)),
                               CHK_PREDICT, NO_RESULT);
                    fed++;
                end
            end else begin
                nbuf = int'($urandom_range(1, 6));
                for (int b = 0; b < nbuf; b++) begin
                    if (buf_no == 0) begin
                        len = alc_pkg::BUFFER_DEPTH;
                    end else if (buf_no == 1) begin
                        len = alc_pkg::BUFFER_DEPTH + 44;
                    end else begin
                        val = int'($urandom_range(0, 99));
                        if (val < 80) len = int'($urandom_range(1, 16));
                        else if (val < 96) len = int'($urandom_range(17, 64));
                        else len = int'($urandom_range(250, 300));
                    end
                    buf_no++;
                    // An unterminated buffer carries over into the next phase.
                    cut = (b == nbuf - 1 && $urandom_range(0, 3) == 0) ?
                          int'($urandom_range(0, len - 1)) : len;
                    mode = int'($urandom_range(0, 3));
                    base = int'($urandom_range(0, 255)) - 128;
                    spread = int'($urandom_range(0, 15));
                    for (int i = 0; i < cut; i++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            drive_item(alc_pkg::OP_FLUSH,
                                       alc_pkg::SAMPLE_W'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)),
                                       CHK_PREDICT, NO_RESULT);
                            fed++;
                        end
                        if ($urandom_range(0, 49) == 0) begin
                            drain_results();
                        end
                        case (mode)
                            0: val = int'($urandom_range(0, 255));
                            1: val = base + int'($urandom_range(0, 2 * spread)) - spread;
                            2: val = base;
                            default: val = (i % 2 != 0) ? 127 : -128;
                        endcase
                        if (val > 127) val = 127;
                        if (val < -128) val = -128;
                        drive_item(alc_pkg::OP_SAMPLE, val[alc_pkg::SAMPLE_W-1:0], (i == len - 1),
                                   CHK_PREDICT, NO_RESULT);
                        fed++;
                    end
                end
            end
        end

        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: audio_level_and_chunker_unit.f
design/alc_pkg.sv
design/audio_level_and_chunker_unit.sv
tb/sv/tb_audio_level_and_chunker_unit.sv
